// ----- hw/rtl/dual_window_average_change_detector_defines.svh -----
// Assertion macros for the checker file.
`ifndef DUAL_WINDOW_AVERAGE_CHANGE_DETECTOR_DEFINES_SVH
`define DUAL_WINDOW_AVERAGE_CHANGE_DETECTOR_DEFINES_SVH
// Check that a condition implies a consequence in the same cycle.
`define DWA_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define DWA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/dwacd_pkg.sv -----
// ----------------------------------------------------------------------------
// dwacd_pkg
// Types and constants for the dual window average change detector.
// ----------------------------------------------------------------------------
package dwacd_pkg;
    localparam int SHORT_MAX = 16;
    localparam int LONG_MAX  = 512;
    localparam int SIW = $clog2(SHORT_MAX);
    localparam int LIW = $clog2(LONG_MAX);
    localparam int SCW = $clog2(SHORT_MAX + 1);
    localparam int LCW = $clog2(LONG_MAX + 1);
    localparam int SSW = 8 + SCW;
    localparam int LSW = 8 + LCW;
    localparam int CFG_W = 10;
    localparam int QDEPTH = 2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SHORT_LEN = 2'd1;
    localparam logic [1:0] REG_LONG_LEN  = 2'd2;

    localparam logic [7:0] THRESHOLD_RESET = 8'd10;
    localparam logic [4:0] SHORT_RESET     = 5'd10;
    localparam logic [9:0] LONG_RESET      = 10'd300;

    typedef enum logic [1:0] {
        OP_SAMPLE    = 2'd0,
        OP_MONITOR   = 2'd1,
        OP_CALIBRATE = 2'd2,
        OP_NONE      = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_UPDATE, ST_FILL, ST_START, ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] humidity_sample;
        logic [7:0] temperature_sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        humidity_short_avg;
        logic [7:0]        humidity_long_avg;
        logic [7:0]        temperature_short_avg;
        logic [7:0]        temperature_long_avg;
        logic signed [7:0] humidity_delta;
        logic              change_event;
        logic              calibrate_done;
    } t_out_item;

    // classified command handed from the front to the back
    typedef struct packed {
        t_opcode    op;
        logic [7:0] hv;
        logic [7:0] tv;
    } t_cmd;
endpackage

// ----- hw/rtl/dual_window_average_change_detector.sv -----
// ----------------------------------------------------------------------------
// dual_window_average_change_detector
// Short and long moving averages of humidity and temperature with a
// humidity change detector.
// ----------------------------------------------------------------------------
// From input transfer to result valid, a sample passes the read, update and
// start states and four runs of the serial divider; monitor or unused opcode
// runs the divider from the read state; calibrate adds two divider runs and a
// sweep of the long stores. One item at a time; the back takes the next queued
// command in the cycle after the result transfer; the queue holds two items.
// Reset: synchronous active low; stores are not cleared, sums and counts are.
module dual_window_average_change_detector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dwacd_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dwacd_pkg::t_out_item o_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [9:0]           i_cfg_data
);
    import dwacd_pkg::*;

    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    dwacd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    dwacd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );
endmodule

// ----- hw/rtl/dwacd_front.sv -----
// ----------------------------------------------------------------------------
// dwacd_front
// Accepts input items, classifies the opcode and queues commands.
// ----------------------------------------------------------------------------
module dwacd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dwacd_pkg::t_in_item i_data,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop,
    output dwacd_pkg::t_cmd     o_cmd
);
    import dwacd_pkg::*;

    t_cmd       r_q [QDEPTH];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_cmd       cmd;

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd.op = t_opcode'(i_data.opcode);
        cmd.hv = i_data.humidity_sample;
        cmd.tv = i_data.temperature_sample;
        n_wp   = push ? ~r_wp : r_wp;
        n_rp   = i_cmd_pop ? ~r_rp : r_rp;
        n_cnt  = r_cnt + 2'(push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule

// ----- hw/rtl/dwacd_divider.sv -----
// ----------------------------------------------------------------------------
// dwacd_divider
// Restoring divider, one quotient bit per cycle, low 8 bits of the quotient.
// ----------------------------------------------------------------------------
module dwacd_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [dwacd_pkg::LSW-1:0] i_num,
    input  logic [dwacd_pkg::LCW-1:0] i_den,
    output logic                      o_done,
    output logic [7:0]                o_quot
);
    import dwacd_pkg::*;

    localparam int CW = $clog2(LSW + 1);

    logic [LSW-1:0] r_num, n_num;
    logic [LCW-1:0] r_rem, n_rem;
    logic [LCW-1:0] r_den;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic [LCW:0]   trial;

    assign o_done = r_busy && (r_cnt == CW'(0));
    assign o_quot = r_num[7:0];

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        trial  = {r_rem, r_num[LSW-1]};
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_cnt  = CW'(LSW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_cnt == CW'(0)) begin
                n_busy = 1'b0;
            end else begin
                // shift in one bit, subtract when it fits
                if (trial >= {1'b0, r_den}) begin
                    n_rem = LCW'(trial - {1'b0, r_den});
                    n_num = {r_num[LSW-2:0], 1'b1};
                end else begin
                    n_rem = trial[LCW-1:0];
                    n_num = {r_num[LSW-2:0], 1'b0};
                end
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end
endmodule

// ----- hw/rtl/dwacd_back.sv -----
// ----------------------------------------------------------------------------
// dwacd_back
// Executes commands: ring updates, calibration and averaging.
// ----------------------------------------------------------------------------
module dwacd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [9:0]           i_cfg_data,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_pop,
    input  dwacd_pkg::t_cmd      i_cmd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dwacd_pkg::t_out_item o_data
);
    import dwacd_pkg::*;

    logic [7:0] r_hs_mem [SHORT_MAX];
    logic [7:0] r_ts_mem [SHORT_MAX];
    logic [7:0] r_hl_mem [LONG_MAX];
    logic [7:0] r_tl_mem [LONG_MAX];

    logic [7:0]     r_thr;
    logic [4:0]     r_slen_raw;
    logic [9:0]     r_llen_raw;
    logic [SSW-1:0] r_ssum_h, r_ssum_t;
    logic [LSW-1:0] r_lsum_h, r_lsum_t;
    logic [SCW-1:0] r_scnt;
    logic [LCW-1:0] r_lcnt;
    logic [SIW-1:0] r_sidx;
    logic [LIW-1:0] r_lidx;
    logic [7:0]     r_ohs_h, r_ohs_t, r_ohl_h, r_ohl_t;
    t_state         r_state, n_state;
    t_cmd           r_cmd;
    logic [LIW:0]   r_fidx;
    logic [1:0]     r_dsel;
    logic [7:0]     r_avg [4];
    logic           r_ovalid;
    t_out_item      r_out;

    logic [SCW-1:0] slen;
    logic [LCW-1:0] llen;
    logic [SIW-1:0] si, si_next;
    logic [LIW-1:0] li, li_next;
    logic           div_start, div_done;
    logic [1:0]     div_sel;
    logic [LSW-1:0] div_num;
    logic [LCW-1:0] div_den;
    logic [7:0]     div_q;
    logic [7:0]     diff;
    logic           fill_we;

    always_comb begin
        slen = (r_slen_raw == 5'd0) ? SCW'(1)
             : (SCW'(r_slen_raw) > SCW'(SHORT_MAX)) ? SCW'(SHORT_MAX) : SCW'(r_slen_raw);
        llen = (r_llen_raw == 10'd0) ? LCW'(1)
             : (LCW'(r_llen_raw) > LCW'(LONG_MAX)) ? LCW'(LONG_MAX) : LCW'(r_llen_raw);
        si = ({1'b0, r_sidx} >= SCW'(slen)) ? '0 : r_sidx;
        li = ({1'b0, r_lidx} >= LCW'(llen)) ? '0 : r_lidx;
        si_next = ({1'b0, si} + SCW'(1) >= slen) ? '0 : si + SIW'(1);
        li_next = ({1'b0, li} + LCW'(1) >= llen) ? '0 : li + LIW'(1);
    end

    // next state and handshake control
    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        div_start = 1'b0;
        fill_we   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !r_ovalid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = ST_READ;
                end
            end
            ST_READ: begin
                if (r_cmd.op == OP_SAMPLE) begin
                    n_state = ST_UPDATE;
                end else if (r_cmd.op == OP_CALIBRATE) begin
                    div_start = 1'b1;
                    n_state   = ST_FILL;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_UPDATE: begin
                n_state = ST_START;
            end
            ST_FILL: begin
                // wait for both short averages, then sweep the long and short stores
                if (r_dsel == 2'd2) begin
                    fill_we = 1'b1;
                    if (r_fidx == (LIW + 1)'(LONG_MAX - 1)) begin
                        n_state = ST_START;
                    end
                end else if (div_done && r_dsel == 2'd0) begin
                    div_start = 1'b1;
                end
            end
            ST_START: begin
                // sums are settled here, so the first average starts now
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (r_dsel == 2'd3) begin
                        n_state = ST_OUT;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // slots: 0 hs, 1 hl, 2 ts, 3 tl; while dividing start the next slot
    always_comb begin
        if (r_state == ST_DIV) begin
            div_sel = r_dsel + 2'd1;
        end else if (r_state == ST_FILL) begin
            div_sel = 2'd2;
        end else begin
            div_sel = 2'd0;
        end
        case (div_sel)
            2'd1: begin div_num = r_lsum_h;        div_den = r_lcnt;        end
            2'd2: begin div_num = LSW'(r_ssum_t);  div_den = LCW'(r_scnt);  end
            2'd3: begin div_num = r_lsum_t;        div_den = r_lcnt;        end
            default: begin div_num = LSW'(r_ssum_h); div_den = LCW'(r_scnt); end
        endcase
    end

    dwacd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign diff     = r_avg[0] - r_avg[1];
    assign o_valid  = r_ovalid;
    assign o_data   = r_out;

    // sample stores, read-before-write of the evicted entries and the calibration fill
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_ohs_h <= r_hs_mem[si];
            r_ohs_t <= r_ts_mem[si];
            r_ohl_h <= r_hl_mem[li];
            r_ohl_t <= r_tl_mem[li];
        end
        if (r_state == ST_UPDATE) begin
            r_hs_mem[si] <= r_cmd.hv;
            r_ts_mem[si] <= r_cmd.tv;
            r_hl_mem[li] <= r_cmd.hv;
            r_tl_mem[li] <= r_cmd.tv;
        end
        if (fill_we) begin
            r_hl_mem[r_fidx[LIW-1:0]] <= r_avg[0];
            r_tl_mem[r_fidx[LIW-1:0]] <= r_avg[2];
            if (r_fidx < (LIW + 1)'(SHORT_MAX)) begin
                r_hs_mem[r_fidx[SIW-1:0]] <= r_avg[0];
                r_ts_mem[r_fidx[SIW-1:0]] <= r_avg[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_OUT) begin
            r_out.humidity_short_avg    <= r_avg[0];
            r_out.humidity_long_avg     <= r_avg[1];
            r_out.temperature_short_avg <= r_avg[2];
            r_out.temperature_long_avg  <= r_avg[3];
            r_out.humidity_delta        <= diff;
            r_out.change_event   <= (r_cmd.op == OP_MONITOR) && ($signed(diff) > $signed(r_thr));
            r_out.calibrate_done <= (r_cmd.op == OP_CALIBRATE);
        end
        if (div_done) begin
            r_avg[(r_state == ST_FILL && r_dsel == 2'd1) ? 2'd2 : r_dsel] <=
                (((r_state == ST_FILL) || r_dsel[0] == 1'b0) ? (r_scnt == '0)
                                                             : (r_lcnt == '0)) ? 8'd0 : div_q;
        end
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ovalid   <= 1'b0;
            r_thr      <= THRESHOLD_RESET;
            r_slen_raw <= SHORT_RESET;
            r_llen_raw <= LONG_RESET;
            r_ssum_h   <= '0;
            r_ssum_t   <= '0;
            r_lsum_h   <= '0;
            r_lsum_t   <= '0;
            r_scnt     <= '0;
            r_lcnt     <= '0;
            r_sidx     <= '0;
            r_lidx     <= '0;
            r_dsel     <= '0;
            r_fidx     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESHOLD: r_thr <= i_cfg_data[7:0];
                    REG_SHORT_LEN: begin
                        r_slen_raw <= i_cfg_data[4:0];
                        r_ssum_h <= '0;
                        r_ssum_t <= '0;
                        r_scnt   <= '0;
                        r_sidx   <= '0;
                    end
                    REG_LONG_LEN: begin
                        r_llen_raw <= i_cfg_data;
                        r_lsum_h <= '0;
                        r_lsum_t <= '0;
                        r_lcnt   <= '0;
                        r_lidx   <= '0;
                    end
                    default: ;
                endcase
            end
            if (r_state == ST_UPDATE) begin
                if (r_scnt >= slen) begin
                    r_ssum_h <= r_ssum_h - SSW'(r_ohs_h) + SSW'(r_cmd.hv);
                    r_ssum_t <= r_ssum_t - SSW'(r_ohs_t) + SSW'(r_cmd.tv);
                end else begin
                    r_ssum_h <= r_ssum_h + SSW'(r_cmd.hv);
                    r_ssum_t <= r_ssum_t + SSW'(r_cmd.tv);
                    r_scnt   <= r_scnt + SCW'(1);
                end
                if (r_lcnt >= llen) begin
                    r_lsum_h <= r_lsum_h - LSW'(r_ohl_h) + LSW'(r_cmd.hv);
                    r_lsum_t <= r_lsum_t - LSW'(r_ohl_t) + LSW'(r_cmd.tv);
                end else begin
                    r_lsum_h <= r_lsum_h + LSW'(r_cmd.hv);
                    r_lsum_t <= r_lsum_t + LSW'(r_cmd.tv);
                    r_lcnt   <= r_lcnt + LCW'(1);
                end
                r_sidx <= si_next;
                r_lidx <= li_next;
            end
            if (r_state == ST_READ) begin
                r_dsel <= 2'd0;
                r_fidx <= '0;
            end
            if (r_state == ST_FILL) begin
                if (div_done && r_dsel == 2'd0) begin
                    r_dsel <= 2'd1;
                end else if (div_done && r_dsel == 2'd1) begin
                    r_dsel <= 2'd2;
                end else if (r_dsel == 2'd2) begin
                    r_fidx <= r_fidx + (LIW + 1)'(1);
                    if (r_fidx == (LIW + 1)'(LONG_MAX - 1)) begin
                        // sums from a short multiply of the average by the length
                        r_ssum_h <= SSW'(r_avg[0]) * SSW'(slen);
                        r_ssum_t <= SSW'(r_avg[2]) * SSW'(slen);
                        r_lsum_h <= LSW'(r_avg[0]) * LSW'(llen);
                        r_lsum_t <= LSW'(r_avg[2]) * LSW'(llen);
                        r_scnt   <= slen;
                        r_lcnt   <= llen;
                        r_sidx   <= si;
                        r_lidx   <= li;
                        r_dsel   <= 2'd0;
                    end
                end
            end
            if (r_state == ST_UPDATE) begin
                r_dsel <= 2'd0;
            end
            if (r_state == ST_DIV && div_done) begin
                r_dsel <= r_dsel + 2'd1;
            end
        end
    end
endmodule

// ----- hw/rtl/dwacd_checker.sv -----
// ----------------------------------------------------------------------------
// dwacd_checker
// Port-level checks on the detector's result channel.
// ----------------------------------------------------------------------------
`include "dual_window_average_change_detector_defines.svh"
module dwacd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input dwacd_pkg::t_out_item o_data
);
    logic [7:0] delta_check;

    assign delta_check = o_data.humidity_short_avg - o_data.humidity_long_avg;

    `DWA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `DWA_ASSERT_IMP(a_flags, i_clk, i_rst_n, o_valid, !(o_data.change_event && o_data.calibrate_done))
    `DWA_ASSERT_IMP(a_diff, i_clk, i_rst_n, o_valid, o_data.humidity_delta == delta_check)
    `DWA_ASSERT_NEXT(a_gap, i_clk, i_rst_n, o_valid && i_ready, !o_valid)
endmodule

bind dual_window_average_change_detector dwacd_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
